[src/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Shared widths and limits of the decimated RMS level meter.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_W = 16;                 // PCM sample
  localparam int MAG_W    = 16;                 // magnitude, 0..32768
  localparam int PROD_W   = 31;                 // shifted partial product, < 2^31
  localparam int SUM_W    = 43;                 // sum of squares
  localparam int CNT_W    = 13;                 // kept sample count
  localparam int STEP_W   = 11;                 // decimation step register
  localparam int PHASE_W  = 10;                 // position within a group
  localparam int DIVD_W   = SUM_W + 2;          // 4 * sum
  localparam int QUOT_W   = 33;                 // 4*S/C <= 2^32
  localparam int RAD_W    = 34;                 // radicand padded to even width
  localparam int LEVEL_W  = 17;                 // Q1.16 level
  localparam int SQREM_W  = LEVEL_W + 2;        // sqrt partial remainder
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 24;

  localparam logic [STEP_W-1:0] STEP_RESET = 11'd8;
  localparam logic [STEP_W-1:0] STEP_MAX   = 11'd1024;
  localparam logic [CNT_W-1:0]  COUNT_MAX  = 13'd8191;

endpackage

[src/rms_sqacc.sv]
// ----------------------------------------------------------------------------
// rms_sqacc
// Bit-serial square and accumulate: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rms_sqacc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          clear,
  input  logic [rms_pkg::MAG_W-1:0]     mag,
  output logic                          busy,
  output logic [rms_pkg::SUM_W-1:0]     sum
);

  logic                          busy_r, busy_nxt;
  logic [3:0]                    cnt_r, cnt_nxt;
  logic [rms_pkg::MAG_W-1:0]     mplier_r, mplier_nxt;
  logic [rms_pkg::PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [rms_pkg::SUM_W-1:0]     sum_r, sum_nxt;

  // The kept count is capped at 8191 and each square is at most 2^30,
  // so the sum stays below 2^43 - 1 and needs no saturation.
  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    sum_nxt    = sum_r;
    if (clear) begin
      sum_nxt = '0;
    end
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      mplier_nxt = mag;
      mcand_nxt  = {{(rms_pkg::PROD_W-rms_pkg::MAG_W){1'b0}}, mag};
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        sum_nxt = sum_r + {{(rms_pkg::SUM_W-rms_pkg::PROD_W){1'b0}}, mcand_r};
      end
      mplier_nxt = {1'b0, mplier_r[rms_pkg::MAG_W-1:1]};
      mcand_nxt  = {mcand_r[rms_pkg::PROD_W-2:0], 1'b0};
      cnt_nxt    = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
    end
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
  end

  assign busy = busy_r;
  assign sum  = sum_r;

endmodule

[src/rms_div.sv]
// ----------------------------------------------------------------------------
// rms_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rms_pkg::DIVD_W-1:0]    dividend,
  input  logic [rms_pkg::CNT_W-1:0]     divisor,
  output logic                          busy,
  output logic [rms_pkg::QUOT_W-1:0]    quotient
);

  localparam logic [5:0] LAST_IT = 6'(rms_pkg::DIVD_W - 1);

  logic                          busy_r, busy_nxt;
  logic [5:0]                    cnt_r, cnt_nxt;
  logic [rms_pkg::DIVD_W-1:0]    dq_r, dq_nxt;     // dividend out, quotient in
  logic [rms_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [rms_pkg::CNT_W-1:0]     dvs_r, dvs_nxt;
  logic [rms_pkg::CNT_W:0]       trial;
  logic [rms_pkg::CNT_W:0]       diff;
  logic                          qbit;

  always_comb begin
    trial = {rem_r, dq_r[rms_pkg::DIVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[rms_pkg::CNT_W-1:0] : trial[rms_pkg::CNT_W-1:0];
      dq_nxt  = {dq_r[rms_pkg::DIVD_W-2:0], qbit};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == LAST_IT) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  // Mean of 4*s*s never exceeds 2^32: upper quotient bits are zero.
  assign quotient = dq_r[rms_pkg::QUOT_W-1:0];

endmodule

[src/rms_sqrt.sv]
// ----------------------------------------------------------------------------
// rms_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rms_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rms_pkg::QUOT_W-1:0]    radicand,
  output logic                          busy,
  output logic [rms_pkg::LEVEL_W-1:0]   root
);

  localparam int         WORK_W  = rms_pkg::SQREM_W + 2;
  localparam logic [4:0] LAST_IT = 5'(rms_pkg::LEVEL_W - 1);

  logic                          busy_r, busy_nxt;
  logic [4:0]                    cnt_r, cnt_nxt;
  logic [rms_pkg::RAD_W-1:0]     rad_r, rad_nxt;
  logic [rms_pkg::SQREM_W-1:0]   rem_r, rem_nxt;
  logic [rms_pkg::LEVEL_W-1:0]   root_r, root_nxt;
  logic [WORK_W-1:0]             work;
  logic [WORK_W-1:0]             trial;
  logic [WORK_W-1:0]             diff;
  logic                          rbit;

  always_comb begin
    work  = {rem_r, rad_r[rms_pkg::RAD_W-1 -: 2]};
    trial = {{(WORK_W-rms_pkg::LEVEL_W-2){1'b0}}, root_r, 2'b01};
    diff  = work - trial;
    rbit  = (work >= trial);
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = {{(rms_pkg::RAD_W-rms_pkg::QUOT_W){1'b0}}, radicand};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = rbit ? diff[rms_pkg::SQREM_W-1:0] : work[rms_pkg::SQREM_W-1:0];
      root_nxt = {root_r[rms_pkg::LEVEL_W-2:0], rbit};
      rad_nxt  = {rad_r[rms_pkg::RAD_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == LAST_IT) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[src/decimated_rms_level_meter_top.sv]
// A skipped sample is taken in IDLE; a kept sample is then squared bit-serially.
// Final sample: its square (if kept), then the divider, the square-root unit and the
// output register load, with a handoff through the state machine after each unit.
// The shared square unit limits the rate: input waits while a kept sample is squared.
// A finished level waits in the output register while the next buffer streams in.
// Reset (rst_n low, synchronous) clears the sum, count and phase; step returns to 8.
// ----------------------------------------------------------------------------
// decimated_rms_level_meter_top
// Decimating RMS level meter with bit-serial square, divide and root units.
// ----------------------------------------------------------------------------
module decimated_rms_level_meter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rms_pkg::TDATA_IN_W-1:0]     in_tdata,   // [15:0] sample
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rms_pkg::TDATA_OUT_W-1:0]    out_tdata,  // [16:0] level, [23:17] zero
  input  logic                               cfg_wr_en,
  input  logic [rms_pkg::STEP_W-1:0]         cfg_wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [rms_pkg::STEP_W-1:0]      step_r;
  logic [rms_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic [rms_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                            last_r, last_nxt;
  logic                            zero_r, zero_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic [rms_pkg::LEVEL_W-1:0]     level_r, level_nxt;

  logic [rms_pkg::STEP_W-1:0]      step_eff;
  logic [rms_pkg::STEP_W-1:0]      phase_inc;
  logic [rms_pkg::SAMPLE_W-1:0]    sample;
  logic [rms_pkg::MAG_W-1:0]       mag;
  logic                            accept;
  logic                            keep;
  logic                            sq_start, div_start, sqrt_start, load;
  logic                            sq_busy, div_busy, sqrt_busy;
  logic [rms_pkg::SUM_W-1:0]       sum;
  logic [rms_pkg::QUOT_W-1:0]      quotient;
  logic [rms_pkg::LEVEL_W-1:0]     root;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign sample    = in_tdata[rms_pkg::SAMPLE_W-1:0];
  assign mag       = sample[rms_pkg::SAMPLE_W-1] ? (~sample + 16'd1) : sample;
  assign keep      = (phase_r == '0) && (count_r != rms_pkg::COUNT_MAX);

  always_comb begin
    if (step_r == '0) begin
      step_eff = 11'd1;
    end else if (step_r > rms_pkg::STEP_MAX) begin
      step_eff = rms_pkg::STEP_MAX;
    end else begin
      step_eff = step_r;
    end
    phase_inc = {1'b0, phase_r} + 11'd1;
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    zero_nxt   = zero_r;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_tlast;
          // wrap the phase; a final sample restarts it for the next buffer
          if (in_tlast || (phase_inc >= step_eff)) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_inc[rms_pkg::PHASE_W-1:0];
          end
          if (keep) begin
            sq_start  = 1'b1;
            count_nxt = count_r + 13'd1;
            state_nxt = S_SQ;
          end else if (in_tlast) begin
            div_start = 1'b1;
            zero_nxt  = (count_r == '0);
            count_nxt = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_SQ: begin
        if (!sq_busy) begin
          if (last_r) begin
            div_start = 1'b1;
            zero_nxt  = (count_r == '0);
            count_nxt = '0;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!sqrt_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    level_nxt  = level_r;
    if (load) begin
      ovalid_nxt = 1'b1;
      level_nxt  = zero_r ? '0 : root;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= rms_pkg::STEP_RESET;
      phase_r  <= '0;
      count_r  <= '0;
      last_r   <= 1'b0;
      zero_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
      zero_r   <= zero_nxt;
      ovalid_r <= ovalid_nxt;
    end
    level_r <= level_nxt;
  end

  rms_sqacc u_sqacc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .clear (div_start),
    .mag   (mag),
    .busy  (sq_busy),
    .sum   (sum)
  );

  rms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum, 2'b00}),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  rms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (quotient),
    .busy     (sqrt_busy),
    .root     (root)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(rms_pkg::TDATA_OUT_W-rms_pkg::LEVEL_W){1'b0}}, level_r};

endmodule

[src/rms_chk.sv]
// ----------------------------------------------------------------------------
// rms_chk
// Port-level checks on the level meter, bound to the top level.
// ----------------------------------------------------------------------------
module rms_chk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic                               in_tlast,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [rms_pkg::TDATA_OUT_W-1:0]    out_tdata
);

  // hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result request dropped or changed");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:17] == 7'd0) && (out_tdata[16:0] <= 17'd65536))
    else $error("level out of Q1.16 range");

  // a final sample starts the square or the divide, so input stalls next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready && !$rose(out_tvalid))
    else $error("final sample did not start level computation");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind decimated_rms_level_meter_top rms_chk u_rms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
